FILE: rtl/bra_pkg.sv
// Shared types and constants for the best rational approximation block.
`timescale 1ns / 1ps
`default_nettype none

package bra_pkg;

    // Width of numerator, denominator and bound values.
    localparam int NUM_W  = 31;
    // Width of a continued-fraction term that is still allowed (up to 2^32).
    localparam int TERM_W = 33;
    // Width of one multiply-add result: a term times a value plus a value.
    localparam int PROD_W = TERM_W + NUM_W + 1;

    localparam logic [NUM_W-1:0]  NUM_LIMIT  = {NUM_W{1'b1}};
    localparam logic [63:0]       TERM_LIMIT = 64'h0000_0001_0000_0000;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOP,
        ST_DIV,
        ST_MUL_P,
        ST_MUL_Q,
        ST_CHECK,
        ST_OUT
    } bra_state_t;

endpackage

`default_nettype wire

FILE: rtl/bra_divider.sv
// Restoring radix-2 divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module bra_divider
    import bra_pkg::*;
#(
    parameter int DW = 33,
    parameter int VW = 32
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [DW-1:0] dividend,
    input  wire logic [VW-1:0] divisor,
    output logic               done,
    output logic [DW-1:0]      quotient,
    output logic [VW-1:0]      remainder
);

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] quo_reg, quo_next;
    logic [VW-1:0] rem_reg, rem_next;
    logic [VW-1:0] dsr_reg, dsr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;

    logic [VW:0] shifted;
    logic [VW:0] diff;
    logic        fits;

    // One restoring step: bring down the next dividend bit and try a subtract.
    always_comb
    begin
        shifted = {rem_reg, quo_reg[DW-1]};
        diff    = shifted - {1'b0, dsr_reg};
        fits    = (shifted >= {1'b0, dsr_reg});
    end

    // Step counter and datapath control.
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = CW'(DW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DW-2:0], fits};
            rem_next = fits ? diff[VW-1:0] : shifted[VW-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

FILE: rtl/bra_muladd.sv
// Registered multiply-add unit shared by the numerator and denominator updates.
`timescale 1ns / 1ps
`default_nettype none

module bra_muladd
    import bra_pkg::*;
(
    input  wire logic              clk,
    input  wire logic [TERM_W-1:0] term,
    input  wire logic [NUM_W-1:0]  mult,
    input  wire logic [NUM_W-1:0]  addend,
    output logic [PROD_W-1:0]      sum
);

    logic [TERM_W+NUM_W-1:0] prod;
    logic [PROD_W-1:0]       sum_reg, sum_next;

    // Term times the previous convergent value, plus the one before it.
    always_comb
    begin
        prod     = {{NUM_W{1'b0}}, term} * {{TERM_W{1'b0}}, mult};
        sum_next = {1'b0, prod} + {{(PROD_W-NUM_W){1'b0}}, addend};
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
    end

    assign sum = sum_reg;

endmodule

`default_nettype wire

FILE: rtl/best_rational_approximation.sv
// Top level: continued-fraction expansion and best convergent within a bound.
//
//  Channel | Direction | Beat contents
//  --------+-----------+------------------------------------------------
//  s_*     | in        | x_value [63:0], max_denominator [94:64]
//  m_*     | out       | numerator [30:0], denominator [61:31]
//
// Beyond the integer part, one beat expands at most MAX_TERMS - 1 terms, each
// through the shared bit-serial divider. Reset clears only the sequencer
// and the divider control; the block is ready once reset is released.
// s_tready is low from acceptance until the result beat is taken, and a
// stalled result holds on m_tdata.
`timescale 1ns / 1ps
`default_nettype none

module best_rational_approximation
    import bra_pkg::*;
#(
    parameter int MAX_TERMS = 40,
    parameter int FRAC_BITS = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // x_value [63:0], max_denominator [94:64], zero [95]
    input  wire logic [95:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // numerator [30:0], denominator [61:31], zero [63:62]
    output logic [63:0]      m_tdata
);

    localparam int DW = FRAC_BITS + 1;
    localparam int VW = FRAC_BITS;
    localparam int KW = $clog2(MAX_TERMS + 1);

    bra_state_t state_reg, state_next;

    logic [DW-1:0]    u_reg, u_next;
    logic [VW-1:0]    v_reg, v_next;
    logic [TERM_W-1:0] a_reg, a_next;
    logic [NUM_W-1:0] p1_reg, p1_next, q1_reg, q1_next;
    logic [NUM_W-1:0] p2_reg, p2_next, q2_reg, q2_next;
    logic [NUM_W-1:0] pn_reg, pn_next;
    logic             pn_over_reg, pn_over_next;
    logic [NUM_W-1:0] best_p_reg, best_p_next, best_q_reg, best_q_next;
    logic [NUM_W-1:0] bound_reg, bound_next;
    logic [KW-1:0]    k_reg, k_next;

    logic [63:0]      x_in;
    logic [NUM_W-1:0] bound_in;
    logic [63:0]      a0_wide;

    logic             div_start;
    logic             div_done;
    logic [DW-1:0]    div_quo;
    logic [VW-1:0]    div_rem;
    logic [63:0]      quo_wide;

    logic [NUM_W-1:0]  mul_mult, mul_addend;
    logic [PROD_W-1:0] mul_sum;

    assign x_in     = s_tdata[63:0];
    assign bound_in = s_tdata[94:64];
    assign a0_wide  = x_in >> FRAC_BITS;
    assign quo_wide = {{(64-DW){1'b0}}, div_quo};

    bra_divider #(
        .DW (DW),
        .VW (VW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (u_reg),
        .divisor   (v_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    bra_muladd u_mul (
        .clk    (clk),
        .term   (a_reg),
        .mult   (mul_mult),
        .addend (mul_addend),
        .sum    (mul_sum)
    );

    // Operand select for the multiply-add: numerator pass, then denominator.
    always_comb
    begin
        if (state_reg == ST_MUL_P)
        begin
            mul_mult   = p1_reg;
            mul_addend = p2_reg;
        end
        else
        begin
            mul_mult   = q1_reg;
            mul_addend = q2_reg;
        end
    end

    // Sequencer: next state and datapath updates.
    always_comb
    begin
        state_next   = state_reg;
        u_next       = u_reg;
        v_next       = v_reg;
        a_next       = a_reg;
        p1_next      = p1_reg;
        q1_next      = q1_reg;
        p2_next      = p2_reg;
        q2_next      = q2_reg;
        pn_next      = pn_reg;
        pn_over_next = pn_over_reg;
        best_p_next  = best_p_reg;
        best_q_next  = best_q_reg;
        bound_next   = bound_reg;
        k_next       = k_reg;
        div_start    = 1'b0;
        s_tready     = 1'b0;
        m_tvalid     = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    bound_next = (bound_in == '0) ? NUM_W'(1) : bound_in;
                    u_next     = {1'b1, {VW{1'b0}}};
                    v_next     = x_in[VW-1:0];
                    k_next     = KW'(1);
                    p2_next    = NUM_W'(1);
                    q2_next    = '0;
                    q1_next    = NUM_W'(1);
                    best_q_next = NUM_W'(1);
                    if (a0_wide > {{(64-NUM_W){1'b0}}, NUM_LIMIT})
                    begin
                        best_p_next = NUM_LIMIT;
                        state_next  = ST_OUT;
                    end
                    else
                    begin
                        best_p_next = a0_wide[NUM_W-1:0];
                        p1_next     = a0_wide[NUM_W-1:0];
                        state_next  = ST_LOOP;
                    end
                end
            end

            ST_LOOP:
            begin
                if ((k_reg < KW'(MAX_TERMS)) && (v_reg != '0))
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end

            ST_DIV:
            begin
                if (div_done)
                begin
                    u_next = {1'b0, v_reg};
                    v_next = div_rem;
                    a_next = quo_wide[TERM_W-1:0];
                    if (quo_wide > TERM_LIMIT)
                        state_next = ST_OUT;
                    else
                        state_next = ST_MUL_P;
                end
            end

            ST_MUL_P:
            begin
                state_next = ST_MUL_Q;
            end

            ST_MUL_Q:
            begin
                // The numerator product arrives while the denominator is issued.
                pn_next      = mul_sum[NUM_W-1:0];
                pn_over_next = (mul_sum > {{(PROD_W-NUM_W){1'b0}}, NUM_LIMIT});
                state_next   = ST_CHECK;
            end

            ST_CHECK:
            begin
                if (pn_over_reg ||
                    (mul_sum > {{(PROD_W-NUM_W){1'b0}}, bound_reg}))
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    p2_next     = p1_reg;
                    q2_next     = q1_reg;
                    p1_next     = pn_reg;
                    q1_next     = mul_sum[NUM_W-1:0];
                    best_p_next = pn_reg;
                    best_q_next = mul_sum[NUM_W-1:0];
                    k_next      = k_reg + 1'b1;
                    state_next  = ST_LOOP;
                end
            end

            ST_OUT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                    state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        u_reg       <= u_next;
        v_reg       <= v_next;
        a_reg       <= a_next;
        p1_reg      <= p1_next;
        q1_reg      <= q1_next;
        p2_reg      <= p2_next;
        q2_reg      <= q2_next;
        pn_reg      <= pn_next;
        pn_over_reg <= pn_over_next;
        best_p_reg  <= best_p_next;
        best_q_reg  <= best_q_next;
        bound_reg   <= bound_next;
        k_reg       <= k_next;
    end

    assign m_tdata = {2'b00, best_q_reg, best_p_reg};

endmodule

`default_nettype wire
